// ===== rtl/core/sstq_pkg.sv =====
// Shared types and constants of the sorted sleep timer queue.
package sstq_pkg;

    localparam int TIME_W    = 32;
    localparam int UNITS_W   = 16;
    localparam int TPU_W     = 16;
    localparam int TAG_MAX_W = 16;

    localparam logic [TPU_W-1:0] TPU_RESET = TPU_W'(100);

    localparam logic REQ_PAUSE = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    localparam logic KIND_WOKEN  = 1'b0;
    localparam logic KIND_REJECT = 1'b1;

    typedef struct packed {
        logic                 is_tick;
        logic [TAG_MAX_W-1:0] tag;
        logic [TIME_W-1:0]    stamp;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== rtl/core/sstq_if.sv =====
// Handshake channels of the sorted sleep timer queue.
interface sstq_req_if
    import sstq_pkg::*;
#(
    parameter int TAG_BITS = 8
);
    logic                valid;
    logic                ready;
    logic                req_type;
    logic [TAG_BITS-1:0] task_tag;
    logic [UNITS_W-1:0]  sleep_units;
    logic [TIME_W-1:0]   current_time;

    modport source (output valid, req_type, task_tag, sleep_units, current_time,
                    input ready);
    modport sink (input valid, req_type, task_tag, sleep_units, current_time,
                  output ready);
endinterface

interface sstq_res_if #(
    parameter int TAG_BITS = 8
);
    logic                valid;
    logic                ready;
    logic                result_kind;
    logic [TAG_BITS-1:0] woken_tag;
    logic                last_of_run;

    modport source (output valid, result_kind, woken_tag, last_of_run, input ready);
    modport sink (input valid, result_kind, woken_tag, last_of_run, output ready);
endinterface

interface sstq_cfg_if
    import sstq_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [TPU_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== rtl/core/sstq_front.sv =====
// Front end: accepts items, holds the tick rate register, computes wake times.
module sstq_front
    import sstq_pkg::*;
#(
    parameter int TAG_BITS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sstq_req_if.sink   i_req,
    sstq_cfg_if.sink   i_cfg,
    input  t_q_status  i_q_status,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic [TPU_W-1:0]    r_ticks_per_unit;
    logic                r_s1_valid;
    logic                r_s1_tick;
    logic [TAG_BITS-1:0] r_s1_tag;
    logic [TIME_W-1:0]   r_s1_now;
    logic [TIME_W-1:0]   r_s1_prod;
    logic                w_accept;
    logic [TIME_W:0]     w_sum;
    logic [TIME_W-1:0]   w_wake;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = !r_s1_valid || !i_q_status.full;
    assign w_accept    = i_req.valid && i_req.ready;
    assign o_push      = r_s1_valid && !i_q_status.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_unit <= TPU_RESET;
        end else if (i_cfg.valid) begin
            r_ticks_per_unit <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (o_push) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_tick <= i_req.req_type;
            r_s1_tag  <= i_req.task_tag;
            r_s1_now  <= i_req.current_time;
            r_s1_prod <= TIME_W'(i_req.sleep_units) * TIME_W'(r_ticks_per_unit);
        end
    end

    // saturate wake time at the top of the range
    assign w_sum  = {1'b0, r_s1_now} + {1'b0, r_s1_prod};
    assign w_wake = w_sum[TIME_W] ? {TIME_W{1'b1}} : w_sum[TIME_W-1:0];

    always_comb begin
        o_cmd.is_tick = r_s1_tick;
        o_cmd.tag     = TAG_MAX_W'(r_s1_tag);
        o_cmd.stamp   = (r_s1_tick == REQ_TICK) ? r_s1_now : w_wake;
    end

endmodule

// ===== rtl/core/sstq_cmd_fifo.sv =====
// Two-entry command queue between front end and sorted store.
module sstq_cmd_fifo
    import sstq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_cmd,
    output t_q_status o_status
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_status.full  = (r_cnt == CW'(DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;
    assign o_cmd  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// ===== rtl/core/sstq_back.sv =====
// Back end: sorted wake-time store, insertion, expiry pops and result register.
module sstq_back
    import sstq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    sstq_res_if.source o_res
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [TIME_W-1:0]   r_wake [QUEUE_DEPTH];
    logic [TAG_BITS-1:0] r_tag  [QUEUE_DEPTH];
    logic [CW-1:0]       r_count;
    logic                r_out_valid;
    logic                r_out_kind;
    logic [TAG_BITS-1:0] r_out_tag;
    logic                r_out_last;

    logic [QUEUE_DEPTH-1:0] w_le;
    logic [TAG_BITS-1:0]    w_cmd_tag;
    logic                   w_slot_ok;
    logic                   w_full;
    logic                   w_head_due;
    logic                   w_next_due;
    logic                   w_ins;
    logic                   w_shift;
    logic                   w_emit;
    logic                   w_kind;
    logic [TAG_BITS-1:0]    w_etag;
    logic                   w_last;

    assign w_cmd_tag  = i_cmd.tag[TAG_BITS-1:0];
    assign w_slot_ok  = !r_out_valid || o_res.ready;
    assign w_full     = (r_count == CW'(QUEUE_DEPTH));
    assign w_head_due = (r_count != '0) && (r_wake[0] <= i_cmd.stamp);
    assign w_next_due = (r_count > CW'(1)) && (r_wake[1] <= i_cmd.stamp);

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_le[i] = (CW'(i) < r_count) && (r_wake[i] <= i_cmd.stamp);
        end
    end

    always_comb begin
        o_pop   = 1'b0;
        w_ins   = 1'b0;
        w_shift = 1'b0;
        w_emit  = 1'b0;
        w_kind  = KIND_WOKEN;
        w_etag  = r_tag[0];
        w_last  = 1'b0;
        if (i_cmd_valid) begin
            if (i_cmd.is_tick == REQ_PAUSE) begin
                if (!w_full) begin
                    w_ins = 1'b1;
                    o_pop = 1'b1;
                end else if (w_slot_ok) begin
                    w_emit = 1'b1;
                    w_kind = KIND_REJECT;
                    w_etag = w_cmd_tag;
                    w_last = 1'b1;
                    o_pop  = 1'b1;
                end
            end else begin
                if (!w_head_due) begin
                    o_pop = 1'b1;
                end else if (w_slot_ok) begin
                    w_emit  = 1'b1;
                    w_shift = 1'b1;
                    w_last  = !w_next_due;
                    o_pop   = !w_next_due;
                end
            end
        end
    end

    // insert after equal wake times, or advance the whole row by one on a pop
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (w_ins && !w_le[i]) begin
                if (i == 0 || w_le[(i == 0) ? 0 : i - 1]) begin
                    r_wake[i] <= i_cmd.stamp;
                    r_tag[i]  <= w_cmd_tag;
                end else begin
                    r_wake[i] <= r_wake[(i == 0) ? 0 : i - 1];
                    r_tag[i]  <= r_tag[(i == 0) ? 0 : i - 1];
                end
            end else if (w_shift && i < QUEUE_DEPTH - 1) begin
                r_wake[i] <= r_wake[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
                r_tag[i]  <= r_tag[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_ins) begin
                r_count <= r_count + CW'(1);
            end else if (w_shift) begin
                r_count <= r_count - CW'(1);
            end
            if (w_slot_ok) begin
                r_out_valid <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_kind <= w_kind;
            r_out_tag  <= w_etag;
            r_out_last <= w_last;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.result_kind = r_out_kind;
    assign o_res.woken_tag   = r_out_tag;
    assign o_res.last_of_run = r_out_last;

endmodule

// ===== rtl/core/sorted_sleep_timer_queue.sv =====
// Sorted sleep timer queue: front end, command queue and sorted store.
// Path: a rejected pause and a tick's first woken item pass the front stage register, the
//   command queue and the result register, then one woken item per cycle while that register is free or taken.
// Throughput: the front takes one item per cycle while the two-entry command queue has room;
//   the store retires a pause once stored or rejected, and a tick once no due item is left.
// Reset: empties the store and command queue, sets ticks_per_unit to 100; stored data not cleared.
module sorted_sleep_timer_queue
    import sstq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sstq_req_if.sink   i_req,
    sstq_cfg_if.sink   i_cfg,
    sstq_res_if.source o_res
);

    logic      w_push;
    t_cmd      w_push_cmd;
    t_cmd      w_head_cmd;
    t_q_status w_q_status;
    logic      w_pop;

    sstq_front #(
        .TAG_BITS (TAG_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cfg      (i_cfg),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    sstq_cmd_fifo u_cmd_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_push_cmd),
        .i_pop    (w_pop),
        .o_cmd    (w_head_cmd),
        .o_status (w_q_status)
    );

    sstq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!w_q_status.empty),
        .i_cmd       (w_head_cmd),
        .o_pop       (w_pop),
        .o_res       (o_res)
    );

endmodule
